@@ design/xed_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// xed_pkg: shared types and tables for the XML entity decoder
// Item layouts, the command passed from the front to the back part, and the
// tables of the five predefined entities (amp, lt, gt, quot, apos).
// ----------------------------------------------------------------------------
package xed_pkg;

    localparam int NUM_ENT = 5;
    localparam int NAME_LEN = 5;
    localparam logic [7:0] AMP_CHAR = 8'h26;
    localparam logic [4:0] ALL_CANDIDATES = 5'h1F;

    // Entity indexes, in candidate mask bit order
    localparam logic [2:0] ENT_AMP = 3'd0;
    localparam logic [2:0] ENT_LT = 3'd1;
    localparam logic [2:0] ENT_GT = 3'd2;
    localparam logic [2:0] ENT_QUOT = 3'd3;
    localparam logic [2:0] ENT_APOS = 3'd4;

    typedef struct packed {
        logic [7:0] char_in;
        logic       end_of_text;
    } in_item_t;

    typedef struct packed {
        logic [7:0] char_out;
        logic       has_char;
        logic       last_out;
    } out_item_t;

    // Work for the back part: letters fpos..flen-1 of entity ent, then an
    // optional byte, then an optional end marker.
    typedef struct packed {
        logic [2:0] ent;
        logic [2:0] fpos;
        logic [2:0] flen;
        logic       has_char;
        logic [7:0] ch;
        logic       last;
    } cmd_t;

    typedef logic [NAME_LEN-1:0][7:0] ent_name_t;

    function automatic ent_name_t ent_name(input logic [2:0] ent);
        ent_name_t name;
        unique case (ent)
            ENT_AMP:  name = {8'h00, 8'h3B, 8'h70, 8'h6D, 8'h61};
            ENT_LT:   name = {8'h00, 8'h00, 8'h3B, 8'h74, 8'h6C};
            ENT_GT:   name = {8'h00, 8'h00, 8'h3B, 8'h74, 8'h67};
            ENT_QUOT: name = {8'h3B, 8'h74, 8'h6F, 8'h75, 8'h71};
            ENT_APOS: name = {8'h3B, 8'h73, 8'h6F, 8'h70, 8'h61};
            default:  name = '0;
        endcase
        return name;
    endfunction

    function automatic logic [7:0] ent_letter(input logic [2:0] ent, input logic [2:0] pos);
        ent_name_t name;
        logic [7:0] letter;
        name = ent_name(ent);
        if (pos < 3'(NAME_LEN)) begin
            letter = name[pos];
        end else begin
            letter = 8'h00;
        end
        return letter;
    endfunction

    function automatic logic [2:0] ent_len(input logic [2:0] ent);
        logic [2:0] len;
        unique case (ent)
            ENT_AMP:  len = 3'd4;
            ENT_LT:   len = 3'd3;
            ENT_GT:   len = 3'd3;
            ENT_QUOT: len = 3'd5;
            ENT_APOS: len = 3'd5;
            default:  len = 3'd0;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] ent_char(input logic [2:0] ent);
        logic [7:0] c;
        unique case (ent)
            ENT_AMP:  c = 8'h26;
            ENT_LT:   c = 8'h3C;
            ENT_GT:   c = 8'h3E;
            ENT_QUOT: c = 8'h22;
            ENT_APOS: c = 8'h27;
            default:  c = 8'h00;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

@@ design/xml_entity_decoder.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// xml_entity_decoder: streaming decoder for the predefined XML entities
// Input channel in_valid/in_stall/in_item carries one byte per item with an
// end_of_text flag on the final byte of a string. Output channel
// out_valid/out_stall/out_item carries decoded bytes (has_char = 1) and one
// end-only marker (has_char = 0, last_out = 1) closing each string.
// amp, lt, gt, quot and apos entities become one byte; a broken '&' prefix
// is dropped and its matched letters are passed on as plain text.
// Throughput: one input item per cycle while the command queue has room;
// the output side gives one result per cycle while out_stall is low, so an
// item with n results (n is 0 to 6) holds the expander until all are out.
// Path: an accepted item's command is written into the queue; with the queue
// empty and no stall, its first result then enters the output register.
// in_stall rises only when the QUEUE_DEPTH-entry command queue is full.
// While out_stall is high the output register holds its item; the queue
// absorbs further input until it fills.
// Reset clears the match state, empties the queue and drops out_valid.
// ----------------------------------------------------------------------------
module xml_entity_decoder
    import xed_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_stall,
    input  wire in_item_t  in_item,
    output logic           out_valid,
    input  wire logic      out_stall,
    output out_item_t      out_item
);

    logic accept;
    logic push;
    cmd_t push_cmd;
    logic pop;
    logic q_full;
    logic q_nonempty;
    cmd_t q_head;

    assign in_stall = q_full;
    assign accept = in_valid && !q_full;

    // Match and classify incoming items
    xed_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_item (in_item),
        .push    (push),
        .cmd     (push_cmd)
    );

    // Decouple front and back
    xed_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .full     (q_full),
        .nonempty (q_nonempty),
        .head     (q_head)
    );

    // Expand commands into result items
    xed_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_nonempty (q_nonempty),
        .q_head     (q_head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_item   (out_item)
    );

endmodule
`default_nettype wire

@@ design/xed_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// xed_front: entity matcher and classifier
// Tracks the entity prefix seen so far and turns each accepted item into one
// command for the back part, or none when the item only opens or extends a match.
// ----------------------------------------------------------------------------
module xed_front
    import xed_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     accept,
    input  wire in_item_t in_item,
    output logic          push,
    output cmd_t          cmd
);

    logic       in_entity_reg, in_entity_next;
    logic [2:0] match_len_reg, match_len_next;
    logic [4:0] cand_mask_reg, cand_mask_next;

    logic [4:0] nxt_mask;
    logic       done_hit;
    logic [2:0] done_idx;
    logic [2:0] match_len_inc;
    logic       progress;
    logic       brk;
    logic       fresh;
    logic       is_amp;
    logic [4:0] sel_mask;
    logic [2:0] sel_ent;

    assign match_len_inc = match_len_reg + 3'd1;
    assign is_amp = (in_item.char_in == AMP_CHAR);

    // Compare the byte against the next letter of every live candidate
    always_comb
    begin
        nxt_mask = '0;
        done_hit = 1'b0;
        done_idx = '0;
        for (int i = 0; i < NUM_ENT; i++)
        begin
            if (cand_mask_reg[i] && (match_len_reg < ent_len(3'(i)))
                && (ent_letter(3'(i), match_len_reg) == in_item.char_in))
            begin
                nxt_mask[i] = 1'b1;
                if (match_len_inc == ent_len(3'(i)))
                begin
                    done_hit = 1'b1;
                    done_idx = 3'(i);
                end
            end
        end
    end

    assign progress = in_entity_reg && !done_hit && (nxt_mask != '0);
    assign brk = in_entity_reg && !done_hit && (nxt_mask == '0);
    assign fresh = !in_entity_reg || brk;

    // Pick the lowest live candidate to spell out a flushed prefix
    assign sel_mask = brk ? cand_mask_reg : nxt_mask;
    always_comb
    begin
        sel_ent = '0;
        for (int i = NUM_ENT - 1; i >= 0; i--)
        begin
            if (sel_mask[i])
            begin
                sel_ent = 3'(i);
            end
        end
    end

    // Build the command for this item
    always_comb
    begin
        cmd.ent = sel_ent;
        cmd.fpos = '0;
        cmd.has_char = done_hit || (fresh && !is_amp);
        cmd.ch = done_hit ? ent_char(done_idx) : in_item.char_in;
        cmd.last = in_item.end_of_text;
        if (brk)
        begin
            cmd.flen = match_len_reg;
        end
        else if (in_item.end_of_text && progress)
        begin
            cmd.flen = match_len_inc;
        end
        else
        begin
            cmd.flen = '0;
        end
    end

    assign push = accept && ((cmd.flen != '0) || cmd.has_char || cmd.last);

    // Advance the match state
    always_comb
    begin
        in_entity_next = in_entity_reg;
        match_len_next = match_len_reg;
        cand_mask_next = cand_mask_reg;
        if (accept)
        begin
            match_len_next = '0;
            cand_mask_next = ALL_CANDIDATES;
            in_entity_next = 1'b0;
            if (!in_item.end_of_text)
            begin
                if (progress)
                begin
                    in_entity_next = 1'b1;
                    match_len_next = match_len_inc;
                    cand_mask_next = nxt_mask;
                end
                else if (fresh)
                begin
                    in_entity_next = is_amp;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_entity_reg <= 1'b0;
            match_len_reg <= '0;
            cand_mask_reg <= ALL_CANDIDATES;
        end
        else
        begin
            in_entity_reg <= in_entity_next;
            match_len_reg <= match_len_next;
            cand_mask_reg <= cand_mask_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_open_match: assert property (@(posedge clk) disable iff (!rst_n)
        in_entity_reg |-> (cand_mask_reg != '0) && (match_len_reg <= 3'd4))
        else $error("open match with empty mask or overlong prefix");
    a_idle_match: assert property (@(posedge clk) disable iff (!rst_n)
        !in_entity_reg |-> (match_len_reg == '0) && (cand_mask_reg == ALL_CANDIDATES))
        else $error("match state not cleared outside an entity");
`endif

endmodule
`default_nettype wire

@@ design/xed_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// xed_queue: command queue between front and back
// Small register FIFO; the front stalls only when it is full.
// ----------------------------------------------------------------------------
module xed_queue
    import xed_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    input  wire logic pop,
    output logic      full,
    output logic      nonempty,
    output cmd_t      head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t          mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full = (count_reg == CW'(DEPTH));
    assign nonempty = (count_reg != '0);
    assign head = mem_reg[rd_ptr_reg];

    // Advance pointers with wrap at the depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    // Store commands
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("push into full command queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !nonempty |-> !pop)
        else $error("pop from empty command queue");
`endif

endmodule
`default_nettype wire

@@ design/xed_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// xed_back: result expander
// Turns each command into its results, one per cycle while the receiver does
// not stall, into an output register that holds while the receiver stalls.
// ----------------------------------------------------------------------------
module xed_back
    import xed_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  q_nonempty,
    input  wire cmd_t  q_head,
    output logic       pop,
    output logic       out_valid,
    input  wire logic  out_stall,
    output out_item_t  out_item
);

    logic      cur_valid_reg, cur_valid_next;
    cmd_t      cur_reg, cur_next;
    logic      out_valid_reg, out_valid_next;
    out_item_t out_item_reg;

    cmd_t      work;
    cmd_t      rest;
    out_item_t res;
    logic      work_valid;
    logic      slot_free;
    logic      go;
    logic      rest_pending;

    assign work = cur_valid_reg ? cur_reg : q_head;
    assign work_valid = cur_valid_reg || q_nonempty;
    assign slot_free = !out_valid_reg || !out_stall;
    assign go = work_valid && slot_free;
    assign pop = go && !cur_valid_reg;

    // Produce the next result of the current command
    always_comb
    begin
        rest = work;
        if (work.fpos < work.flen)
        begin
            res.char_out = ent_letter(work.ent, work.fpos);
            res.has_char = 1'b1;
            res.last_out = 1'b0;
            rest.fpos = work.fpos + 3'd1;
        end
        else if (work.has_char)
        begin
            res.char_out = work.ch;
            res.has_char = 1'b1;
            res.last_out = 1'b0;
            rest.has_char = 1'b0;
        end
        else
        begin
            res.char_out = 8'h00;
            res.has_char = 1'b0;
            res.last_out = 1'b1;
            rest.last = 1'b0;
        end
    end

    assign rest_pending = (rest.fpos < rest.flen) || rest.has_char || rest.last;

    // Hold the remainder of a multi-result command
    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        cur_next = cur_reg;
        if (go)
        begin
            cur_valid_next = rest_pending;
            cur_next = rest;
        end
    end

    // Load the output register or drain it
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (go)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (go)
        begin
            out_item_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item = out_item_reg;

`ifndef NO_ASSERTIONS
    a_cur_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> (cur_reg.fpos < cur_reg.flen) || cur_reg.has_char || cur_reg.last)
        else $error("held command has no results left");
`endif

endmodule
`default_nettype wire
